### hdl/spn_pkg.sv
// ----------------------------------------------------------------------------
// spn_pkg
// Shared widths, defaults and register codes of the byte-oriented SPN cipher.
// ----------------------------------------------------------------------------
package spn_pkg;

  localparam int BLOCK_BYTES_DEF = 8;
  localparam int KEY_BYTES_DEF   = 16;
  localparam int MAX_ROUNDS_DEF  = 16;
  localparam int MIN_ROUNDS      = 4;

  localparam int TDATA_W   = 64;
  localparam int KEY_W     = 64;
  localparam int MAP_W     = 24;
  localparam int RCNT_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [MAP_W-1:0]  MAP_RESET  = 24'hFAC688;
  localparam logic [RCNT_W-1:0] RCNT_RESET = 5'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW     = 2'd0,
    REG_KEY_HIGH    = 2'd1,
    REG_BYTE_MAP    = 2'd2,
    REG_ROUND_COUNT = 2'd3
  } cfg_reg_t;

endpackage

### hdl/spn_block_cipher.sv
// ----------------------------------------------------------------------------
// spn_block_cipher
// Unrolled, pipelined byte-oriented SPN cipher: key mix, complement and byte
// permutation per stage, encrypt or decrypt chosen per block.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    s_tuser: kind, s_tdata: block_in
// m_*       out        m_tvalid / m_tready    m_tdata: block_out
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One round per stage, MAX_ROUNDS stages. One block is taken per cycle while
// the first stage is ready. Stages outside the programmed rounds pass
// the block through unchanged, so every block crosses all MAX_ROUNDS stages.
// Reset clears all stage valid bits and loads the default key, map and rounds.
// Each stage holds only when it is full and the next one cannot take its
// contents, so empty stages fill while the output waits.
// ----------------------------------------------------------------------------
module spn_block_cipher
  import spn_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF,
  parameter int MAX_ROUNDS  = MAX_ROUNDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // [63:0] block_in
  input  logic                  s_tuser,   // [0] kind
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // [63:0] block_out
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DW   = BLOCK_BYTES * 8;
  localparam int IW   = $clog2(BLOCK_BYTES);
  localparam int RW   = $clog2(MAX_ROUNDS + 1);
  localparam int LAST = MAX_ROUNDS - 1;

  typedef logic [BLOCK_BYTES-1:0][7:0] blk_t;

  logic [KEY_W-1:0]  key_low_bytes;
  logic [KEY_W-1:0]  key_high_bytes;
  logic [MAP_W-1:0]  byte_source_map;
  logic [RCNT_W-1:0] round_count;

  logic [2*KEY_W-1:0] key_all;
  logic [RW-1:0]      nr;
  logic [5:0]         rc_ext;

  logic [IW-1:0]          src_idx [BLOCK_BYTES];
  logic [BLOCK_BYTES-1:0] inv_sel [BLOCK_BYTES];

  logic             stage_valid [MAX_ROUNDS];
  logic             stage_ready [MAX_ROUNDS+1];
  logic             stage_kind  [MAX_ROUNDS];
  blk_t             stage_data  [MAX_ROUNDS];

  // Fold a 3-bit map field into the block by repeated compare and subtract.
  function automatic logic [IW-1:0] wrap_index(logic [2:0] v);
    logic [3:0] w;
    w = {1'b0, v};
    for (int n = 0; n < 4; n++) begin
      if (w >= 4'(BLOCK_BYTES)) begin
        w = w - 4'(BLOCK_BYTES);
      end
    end
    return IW'(w);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low_bytes   <= '0;
      key_high_bytes  <= '0;
      byte_source_map <= MAP_RESET;
      round_count     <= RCNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_LOW:     key_low_bytes   <= cfg_data[KEY_W-1:0];
        REG_KEY_HIGH:    key_high_bytes  <= cfg_data[KEY_W-1:0];
        REG_BYTE_MAP:    byte_source_map <= cfg_data[MAP_W-1:0];
        REG_ROUND_COUNT: round_count     <= cfg_data[RCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign key_all = {key_high_bytes, key_low_bytes};
  assign rc_ext  = {1'b0, round_count};

  always_comb begin
    if (rc_ext < 6'(MIN_ROUNDS)) begin
      nr = RW'(MIN_ROUNDS);
    end else if (rc_ext > 6'(MAX_ROUNDS)) begin
      nr = RW'(MAX_ROUNDS);
    end else begin
      nr = RW'(rc_ext);
    end
  end

  // Forward source per output byte; inverse picks the lowest output byte per source.
  always_comb begin
    logic taken;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      src_idx[i] = wrap_index(byte_source_map[3*i +: 3]);
    end
    for (int k = 0; k < BLOCK_BYTES; k++) begin
      taken      = 1'b0;
      inv_sel[k] = '0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin
        if (!taken && src_idx[i] == IW'(k)) begin
          inv_sel[k][i] = 1'b1;
          taken         = 1'b1;
        end
      end
    end
  end

  assign stage_ready[MAX_ROUNDS] = m_tready;
  assign s_tready                = stage_ready[0];

  genvar s, j;
  generate
    for (s = 0; s < MAX_ROUNDS; s++) begin : g_stage
      localparam int DEC_D = MAX_ROUNDS - s;

      blk_t  sk_enc_a, sk_enc_b, sk_dec_a, sk_dec_b;
      blk_t  din, dout, mixed, fwd, inv;
      logic  vin, kin;

      for (j = 0; j < BLOCK_BYTES; j++) begin : g_key
        localparam int KEA = (j + 3 * s + 1) % KEY_BYTES;
        localparam int KEB = (j + 3 * (s + 1) + 1) % KEY_BYTES;
        localparam int KDA = (j + 3 * DEC_D + 1) % KEY_BYTES;
        localparam int KDB = (j + 3 * (DEC_D - 1) + 1) % KEY_BYTES;
        assign sk_enc_a[j] = key_all[8*KEA +: 8];
        assign sk_enc_b[j] = key_all[8*KEB +: 8];
        assign sk_dec_a[j] = key_all[8*KDA +: 8];
        assign sk_dec_b[j] = key_all[8*KDB +: 8];
      end

      if (s == 0) begin : g_head
        assign vin = s_tvalid;
        assign kin = s_tuser;
        assign din = blk_t'(s_tdata[DW-1:0]);
      end else begin : g_body
        assign vin = stage_valid[s-1];
        assign kin = stage_kind[s-1];
        assign din = stage_data[s-1];
      end

      assign stage_ready[s] = !stage_valid[s] || stage_ready[s+1];

      always_comb begin
        mixed = ~(din ^ sk_enc_a);
        for (int i = 0; i < BLOCK_BYTES; i++) begin
          fwd[i] = mixed[src_idx[i]];
          inv[i] = '0;
          for (int m = 0; m < BLOCK_BYTES; m++) begin
            inv[i] = inv[i] | (din[m] & {8{inv_sel[i][m]}});
          end
        end
        dout = din;
        if (!kin) begin
          if (RW'(s + 1) < nr) begin
            dout = fwd;
          end else if (RW'(s + 1) == nr) begin
            dout = mixed ^ sk_enc_b;
          end
        end else begin
          if (RW'(DEC_D) == nr) begin
            dout = ~(din ^ sk_dec_a) ^ sk_dec_b;
          end else if (RW'(DEC_D) < nr) begin
            dout = ~inv ^ sk_dec_b;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[s] <= 1'b0;
        end else if (stage_ready[s]) begin
          stage_valid[s] <= vin;
        end
      end

      always_ff @(posedge clk) begin
        if (stage_ready[s]) begin
          stage_kind[s] <= kin;
          stage_data[s] <= dout;
        end
      end
    end
  endgenerate

  assign m_tvalid = stage_valid[LAST];
  assign m_tdata  = TDATA_W'(stage_data[LAST]);

endmodule

### hdl/spn_port_checker.sv
// ----------------------------------------------------------------------------
// spn_port_checker
// Port-level checks of the SPN cipher: output hold, occupancy and latency.
// ----------------------------------------------------------------------------
module spn_port_checker
  import spn_pkg::*;
#(
  parameter int DEPTH = MAX_ROUNDS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [TDATA_W-1:0]    m_tdata    // [63:0] block_out
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] inflight;
  logic [CW-1:0] inflight_next;
  logic          in_xfer;
  logic          out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  always_comb begin
    inflight_next = inflight;
    if (in_xfer && !out_xfer) begin
      inflight_next = inflight + CW'(1);
    end else if (out_xfer && !in_xfer) begin
      inflight_next = inflight - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transfer dropped or changed while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != '0)
    else $error("output without a pending input");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (inflight == CW'(DEPTH)) && !out_xfer |-> !s_tready)
    else $error("input taken with every stage full");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (inflight == '0) |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind spn_block_cipher spn_port_checker #(.DEPTH(MAX_ROUNDS)) u_port_checker (.*);

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level testbench for spn_block_cipher. A clocked driver feeds blocks
// from a pending queue and predicts each accepted block with an in-bench model
// of the cipher. A clocked monitor compares every output transfer against the
// oldest prediction. Phases reprogram key, byte map and round count while the
// pipeline is empty, vary sender gaps and receiver stalls, and include two
// long output hold-offs that back up the pipeline.
// ----------------------------------------------------------------------------
module tb;
  import spn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic KIND_ENCRYPT = 1'b0;
  localparam logic KIND_DECRYPT = 1'b1;
  localparam int   IDLE_LIMIT   = 4000;
  localparam int   HOLD_CYCLES  = 300;
  localparam int   PRINT_LIMIT  = 100;

  typedef struct {
    logic              kind;
    logic [TDATA_W-1:0] block;
  } cipher_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // cipher settings as programmed into the block
  logic [KEY_W-1:0]  key_low = '0;
  logic [KEY_W-1:0]  key_high = '0;
  logic [MAP_W-1:0]  byte_map = MAP_RESET;
  logic [RCNT_W-1:0] round_count = RCNT_RESET;

  cipher_item_t       pending_blocks[$];
  logic [TDATA_W-1:0] expected_blocks[$];
  cipher_item_t       next_item;
  logic [TDATA_W-1:0] want_block;

  int blocks_queued = 0;
  int results_checked = 0;
  int error_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_epoch = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  spn_block_cipher dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [TDATA_W-1:0] round_subkey(int r);
    logic [2*KEY_W-1:0] key_all;
    logic [TDATA_W-1:0] sk;
    key_all = {key_high, key_low};
    for (int j = 0; j < BLOCK_BYTES_DEF; j++) begin
      sk[8*j +: 8] = key_all[8*((j + 3*r + 1) % KEY_BYTES_DEF) +: 8];
    end
    return sk;
  endfunction

  function automatic logic [TDATA_W-1:0] permute_forward(logic [TDATA_W-1:0] x);
    logic [TDATA_W-1:0] t;
    int src;
    for (int i = 0; i < BLOCK_BYTES_DEF; i++) begin
      src = int'(byte_map[3*i +: 3]) % BLOCK_BYTES_DEF;
      t[8*i +: 8] = x[8*src +: 8];
    end
    return t;
  endfunction

  // first output byte mapped onto a source wins; unmapped bytes read zero
  function automatic logic [TDATA_W-1:0] permute_inverse(logic [TDATA_W-1:0] x);
    logic [TDATA_W-1:0]         t;
    logic [BLOCK_BYTES_DEF-1:0] taken;
    int src;
    t = '0;
    taken = '0;
    for (int i = 0; i < BLOCK_BYTES_DEF; i++) begin
      src = int'(byte_map[3*i +: 3]) % BLOCK_BYTES_DEF;
      if (!taken[src]) begin
        t[8*src +: 8] = x[8*i +: 8];
        taken[src] = 1'b1;
      end
    end
    return t;
  endfunction

  function automatic logic [TDATA_W-1:0] cipher_result(logic kind, logic [TDATA_W-1:0] block);
    int nr;
    logic [TDATA_W-1:0] x;
    nr = int'(round_count);
    if (nr < MIN_ROUNDS) nr = MIN_ROUNDS;
    if (nr > MAX_ROUNDS_DEF) nr = MAX_ROUNDS_DEF;
    x = block;
    if (kind == KIND_ENCRYPT) begin
      for (int r = 0; r < nr - 1; r++) begin
        x = permute_forward(~(x ^ round_subkey(r)));
      end
      x = ~(x ^ round_subkey(nr - 1)) ^ round_subkey(nr);
    end else begin
      x = ~(x ^ round_subkey(nr)) ^ round_subkey(nr - 1);
      for (int r = nr - 1; r > 0; r--) begin
        x = ~permute_inverse(x) ^ round_subkey(r - 1);
      end
    end
    return x;
  endfunction

  function automatic logic [TDATA_W-1:0] random_block();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [MAP_W-1:0] random_permutation_map();
    int perm[BLOCK_BYTES_DEF];
    int j;
    int swap;
    logic [MAP_W-1:0] m;
    for (int i = 0; i < BLOCK_BYTES_DEF; i++) perm[i] = i;
    for (int i = BLOCK_BYTES_DEF - 1; i > 0; i--) begin
      j = $urandom_range(i);
      swap = perm[i];
      perm[i] = perm[j];
      perm[j] = swap;
    end
    for (int i = 0; i < BLOCK_BYTES_DEF; i++) m[3*i +: 3] = perm[i][2:0];
    return m;
  endfunction

  task automatic report_mismatch(string what, logic [TDATA_W-1:0] got,
                                 logic [TDATA_W-1:0] want);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  task automatic write_register(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (index)
      REG_KEY_LOW:     key_low = value;
      REG_KEY_HIGH:    key_high = value;
      REG_BYTE_MAP:    byte_map = value[MAP_W-1:0];
      REG_ROUND_COUNT: round_count = value[RCNT_W-1:0];
      default: ;
    endcase
  endtask

  // junk above the field checks that the block ignores it
  task automatic set_cipher(logic [KEY_W-1:0] k_low, logic [KEY_W-1:0] k_high,
                            logic [MAP_W-1:0] map, logic [RCNT_W-1:0] rounds);
    logic [CFG_DATA_W-1:0] junk;
    junk = ($urandom_range(1) == 1) ? random_block() : '0;
    write_register(REG_KEY_LOW, k_low);
    write_register(REG_KEY_HIGH, k_high);
    write_register(REG_BYTE_MAP, {junk[CFG_DATA_W-1:MAP_W], map});
    write_register(REG_ROUND_COUNT, {junk[CFG_DATA_W-1:RCNT_W], rounds});
  endtask

  task automatic send_block(logic kind, logic [TDATA_W-1:0] block);
    cipher_item_t item;
    item.kind = kind;
    item.block = block;
    pending_blocks.push_back(item);
    blocks_queued++;
  endtask

  task automatic send_round_trip(logic [TDATA_W-1:0] plain);
    send_block(KIND_ENCRYPT, plain);
    send_block(KIND_DECRYPT, cipher_result(KIND_ENCRYPT, plain));
  endtask

  task automatic set_pacing(int mode);
    case (mode % 4)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
      default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (results_checked < blocks_queued) @(posedge clk);
  endtask

  task automatic run_random_phase(int count, int mode, bit long_hold);
    logic [MAP_W-1:0]  map;
    logic [RCNT_W-1:0] rounds;
    int n;
    map = ($urandom_range(3) == 0) ? MAP_W'($urandom) : random_permutation_map();
    case ($urandom_range(4))
      0:       rounds = RCNT_W'(MIN_ROUNDS);
      1:       rounds = RCNT_W'(MAX_ROUNDS_DEF);
      default: rounds = RCNT_W'($urandom_range(31));
    endcase
    set_cipher(random_block(), random_block(), map, rounds);
    set_pacing(mode);
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) < 6) begin
        send_round_trip(random_block());
        n += 2;
      end else begin
        send_block(logic'($urandom_range(1)), random_block());
        n++;
      end
    end
    if (long_hold) hold_epoch++;
    wait_drained();
  endtask

  // driver: predict on each input transfer, then offer the next block
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_blocks.push_back(cipher_result(s_tuser, s_tdata));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_item = pending_blocks.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_item.block;
          s_tuser  <= next_item.kind;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each output transfer, then decide the next ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected block_out", m_tdata, '0);
        end else begin
          want_block = expected_blocks.pop_front();
          if (m_tdata !== want_block) report_mismatch("block_out", m_tdata, want_block);
        end
        results_checked++;
      end
      if (hold_epoch != hold_seen) begin
        hold_seen = hold_epoch;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [MAP_W-1:0] reverse_map;
    logic [TDATA_W-1:0] pattern;
    for (int i = 0; i < BLOCK_BYTES_DEF; i++) reverse_map[3*i +: 3] = 3'(BLOCK_BYTES_DEF - 1 - i);
    pattern = 64'h0123_4567_89AB_CDEF;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: zero key, identity map, minimum rounds
    set_pacing(0);
    send_block(KIND_ENCRYPT, '0);
    send_block(KIND_DECRYPT, '0);
    send_block(KIND_ENCRYPT, '1);
    send_block(KIND_DECRYPT, '1);
    send_round_trip(pattern);
    send_block(KIND_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
    send_block(KIND_DECRYPT, 64'h5555_5555_5555_5555);
    wait_drained();

    // round count below minimum
    set_cipher('1, '1, MAP_RESET, 5'd0);
    send_block(KIND_ENCRYPT, '0);
    send_block(KIND_DECRYPT, '0);
    wait_drained();

    // round count above maximum, reversed byte order
    set_cipher(64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF, reverse_map, 5'd31);
    send_round_trip(random_block());
    wait_drained();

    // all output bytes from byte 0: not a permutation
    set_cipher(random_block(), random_block(), '0, RCNT_W'(MAX_ROUNDS_DEF));
    send_block(KIND_ENCRYPT, '1);
    send_block(KIND_DECRYPT, pattern);
    wait_drained();

    // all output bytes from byte 7
    set_cipher(random_block(), random_block(), '1, 5'd5);
    send_block(KIND_ENCRYPT, pattern);
    send_block(KIND_DECRYPT, ~pattern);
    wait_drained();

    // fixed map fields with repeats
    set_cipher(random_block(), random_block(), 24'h6D2490, RCNT_W'(MIN_ROUNDS));
    send_round_trip(random_block());
    wait_drained();

    for (int p = 0; p < 13; p++) begin
      run_random_phase(118, p, p == 3 || p == 9);
    end

    repeat (4 * MAX_ROUNDS_DEF) @(posedge clk);
    if (expected_blocks.size() != 0) begin
      report_mismatch("blocks never returned", '0, TDATA_W'(expected_blocks.size()));
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/spn_pkg.sv
hdl/spn_block_cipher.sv
hdl/spn_port_checker.sv
test/tb.sv
